// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies c in the same cycle
`define BF_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// condition a implies c in the next cycle
`define BF_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

// File: rtl/core/bf_pkg.sv
// Shared types, constants and helpers of the shortest-path engine
package bf_pkg;

	localparam int VTX_BITS         = 6;
	localparam int SLOT_BITS        = 8;
	localparam int DIST_OUT_BITS    = 22;
	localparam int VCOUNT_BITS      = 7;
	localparam int ECOUNT_BITS      = 9;
	localparam int CFG_ADDR_BITS    = 3;
	localparam int CFG_DATA_BITS    = 32;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam longint DIST_MAX     = 64'sd2097151;
	localparam longint DIST_MIN     = -64'sd2097152;

	// register indexes, taken from paddr[2]
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_EDGE_COUNT   = 1'b1;

	// input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RELAX,
		ST_DRAIN,
		ST_RD,
		ST_EMIT,
		ST_NEG
	} state_t;

	typedef struct packed {
		logic valid;   // edge address presented this cycle
		logic check;   // detection pass: test only, no write-back
		logic clear;   // new run: drop the cycle flag
	} issue_t;

	typedef struct packed {
		logic busy;
		logic neg;
	} relax_stat_t;

	// working distance width: the weight width grown by the vertex and edge count widths, plus one, with sign
	function automatic int dist_bits(int max_v, int max_e, int wb);
		return wb + $clog2(max_v) + $clog2(max_e + 1) + 1;
	endfunction

	function automatic logic [DIST_OUT_BITS-1:0] sat_dist(longint v);
		longint r;
		r = v;
		if (r > DIST_MAX) r = DIST_MAX;
		if (r < DIST_MIN) r = DIST_MIN;
		return r[DIST_OUT_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/bf_in_if.sv
// Input channel: edge loads and run requests
interface bf_in_if #(
	parameter int WEIGHT_BITS = bf_pkg::WEIGHT_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [bf_pkg::SLOT_BITS-1:0]    edge_slot;
	logic [bf_pkg::VTX_BITS-1:0]     from_vertex;
	logic [bf_pkg::VTX_BITS-1:0]     to_vertex;
	logic signed [WEIGHT_BITS-1:0]   edge_weight;
	logic [bf_pkg::VTX_BITS-1:0]     start_vertex;

	modport source (
		output valid, kind, edge_slot, from_vertex, to_vertex, edge_weight, start_vertex,
		input  ready
	);
	modport sink (
		input  valid, kind, edge_slot, from_vertex, to_vertex, edge_weight, start_vertex,
		output ready
	);
endinterface

// File: rtl/core/bf_out_if.sv
// Output channel: per-vertex distances or the negative-cycle word
interface bf_out_if;
	logic                                valid;
	logic                                ready;
	logic [bf_pkg::VTX_BITS-1:0]         vertex;
	logic signed [bf_pkg::DIST_OUT_BITS-1:0] distance;
	logic                                reachable;
	logic                                negative_cycle;
	logic                                last;

	modport source (
		output valid, vertex, distance, reachable, negative_cycle, last,
		input  ready
	);
	modport sink (
		input  valid, vertex, distance, reachable, negative_cycle, last,
		output ready
	);
endinterface

// File: rtl/core/bf_ram.sv
// Generic single-write, single-read RAM with registered read (read-first)
module bf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/bf_relax.sv
// Edge relaxation pipeline: decode edge, read both distances, add/compare, write back
module bf_relax #(
	parameter int MAX_VERTICES = bf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = bf_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = bf_pkg::WEIGHT_BITS_DEF,
	localparam int VB  = bf_pkg::VTX_BITS,
	localparam int VAW = $clog2(MAX_VERTICES),
	localparam int NVW = $clog2(MAX_VERTICES + 1),
	localparam int DW  = bf_pkg::dist_bits(MAX_VERTICES, MAX_EDGES, WEIGHT_BITS),
	localparam int DEW = DW + 1,
	localparam int EW  = 2 * VB + WEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bf_pkg::issue_t      issue,
	input  logic [EW-1:0]       edge_rdata,
	input  logic [NVW-1:0]      nv,
	output logic [VAW-1:0]      raddr_s,
	output logic [VAW-1:0]      raddr_d,
	input  logic [DEW-1:0]      rdata_s,
	input  logic [DEW-1:0]      rdata_d,
	output logic                we,
	output logic [VAW-1:0]      waddr,
	output logic [DEW-1:0]      wdata,
	output bf_pkg::relax_stat_t stat
);
	logic                        v_s1, chk_s1;
	logic [VB-1:0]               from_s1, to_s1;
	logic signed [WEIGHT_BITS-1:0] w_s1;
	logic                        ok_s1;

	logic                        v_s2, chk_s2;
	logic [VAW-1:0]              s_s2, d_s2;
	logic signed [DW-1:0]        w_s2;

	logic                        fwd_v_q;
	logic [VAW-1:0]              fwd_a_q;
	logic [DEW-1:0]              fwd_d_q;
	logic                        neg_q;

	logic [DEW-1:0]              src, dst;
	logic signed [DW-1:0]        src_dist, dst_dist, cand;
	logic                        hit;

	// stage 1: edge word is out of the edge RAM
	assign from_s1 = edge_rdata[EW-1 -: VB];
	assign to_s1   = edge_rdata[EW-VB-1 -: VB];
	assign w_s1    = edge_rdata[WEIGHT_BITS-1:0];
	assign ok_s1   = v_s1 && (int'(from_s1) < int'(nv)) && (int'(to_s1) < int'(nv));
	assign raddr_s = VAW'(from_s1);
	assign raddr_d = VAW'(to_s1);

	// stage 2: distances are out; the previous cycle's write is not yet in them
	always_comb begin
		src = (fwd_v_q && fwd_a_q == s_s2) ? fwd_d_q : rdata_s;
		dst = (fwd_v_q && fwd_a_q == d_s2) ? fwd_d_q : rdata_d;
		src_dist = src[DW-1:0];
		dst_dist = dst[DW-1:0];
		cand = src_dist + w_s2;
		hit = v_s2 && src[DW] && (!dst[DW] || (cand < dst_dist));
		we = hit && !chk_s2;
		waddr = d_s2;
		wdata = {1'b1, cand};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			chk_s1  <= 1'b0;
			v_s2    <= 1'b0;
			chk_s2  <= 1'b0;
			fwd_v_q <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			v_s1    <= issue.valid;
			chk_s1  <= issue.check;
			v_s2    <= ok_s1;
			chk_s2  <= chk_s1;
			fwd_v_q <= we;
			if (issue.clear) begin
				neg_q <= 1'b0;
			end else if (hit && chk_s2) begin
				neg_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		s_s2    <= VAW'(from_s1);
		d_s2    <= VAW'(to_s1);
		w_s2    <= DW'(w_s1);
		fwd_a_q <= d_s2;
		fwd_d_q <= wdata;
	end

	assign stat.busy = v_s1 | v_s2;
	assign stat.neg  = neg_q;
endmodule

// File: rtl/core/bellman_ford_shortest_paths.sv
// Top level: config registers, run sequencer, edge and distance stores, result register
//
//  channel   dir   handshake        word
//  items     in    valid/ready      kind, edge_slot, from/to_vertex, edge_weight, start_vertex
//  results   out   valid/ready      vertex, distance, reachable, negative_cycle, last
//  apb       in    psel/penable     vertex_count @0x0, edge_count @0x4
//
// A run initializes the distance store one vertex at a time, then streams the edges for nv passes,
// one edge per cycle, through the edge RAM read port and the distance RAM read/write ports, drains the
// relaxation pipeline, then reads and emits each vertex result in turn, or emits one negative-cycle word.
// Reset clears control and config only; the edge store holds garbage until loaded.
// Results stall in the output register; no new word is taken until a run has queued its last.
`include "assert_macros.svh"

module bellman_ford_shortest_paths #(
	parameter int MAX_VERTICES = bf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = bf_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = bf_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bf_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [bf_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [bf_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                              pready,
	bf_in_if.sink                             items,
	bf_out_if.source                          results
);
	localparam int VB  = bf_pkg::VTX_BITS;
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int NVW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
	localparam int NEW = $clog2(MAX_EDGES + 1);
	localparam int DW  = bf_pkg::dist_bits(MAX_VERTICES, MAX_EDGES, WEIGHT_BITS);
	localparam int DEW = DW + 1;
	localparam int EW  = 2 * VB + WEIGHT_BITS;
	localparam int CW  = bf_pkg::CFG_DATA_BITS;
	localparam int VCW = bf_pkg::VCOUNT_BITS;
	localparam int ECW = bf_pkg::ECOUNT_BITS;
	localparam int OW  = bf_pkg::DIST_OUT_BITS;

	// configuration
	logic [VCW-1:0] vcount_q;
	logic [ECW-1:0] ecount_q;
	logic           cfg_wr;
	logic [NVW-1:0] nv;
	logic [NEW-1:0] ne;

	// sequencer
	bf_pkg::state_t state_q, state_d;
	logic [NVW-1:0] vtx_q, vtx_d;
	logic [EAW-1:0] edge_q, edge_d;
	logic [NVW-1:0] pass_q, pass_d;
	logic [VB-1:0]  start_q;
	bf_pkg::issue_t issue;
	logic           init_we, load_res, load_neg, run_acc;
	logic           vtx_last, edge_last, out_free;
	logic [VAW-1:0] vtx_idx;

	// stores
	logic           edge_we;
	logic [EW-1:0]  edge_wdata, edge_rdata;
	logic           dist_we;
	logic [VAW-1:0] dist_waddr, rd_addr_a, rd_addr_b;
	logic [DEW-1:0] dist_wdata, rdata_a, rdata_b;

	// relaxation unit
	bf_pkg::relax_stat_t rlx_stat;
	logic [VAW-1:0] rlx_raddr_s, rlx_raddr_d, rlx_waddr;
	logic           rlx_we;
	logic [DEW-1:0] rlx_wdata;

	// result register
	logic           out_valid_q;
	logic [VB-1:0]  vertex_q;
	logic [OW-1:0]  distance_q;
	logic           reachable_q, negcyc_q, last_q;
	logic signed [DW-1:0] rd_dist;
	longint         rd_wide;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			bf_pkg::REG_VERTEX_COUNT: prdata = CW'(vcount_q);
			bf_pkg::REG_EDGE_COUNT:   prdata = CW'(ecount_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCW'(1);
			ecount_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bf_pkg::REG_VERTEX_COUNT: vcount_q <= pwdata[VCW-1:0];
				bf_pkg::REG_EDGE_COUNT:   ecount_q <= pwdata[ECW-1:0];
				default: ;
			endcase
		end
	end

	// effective counts: zero vertices acts as one, both clamp at the store sizes
	always_comb begin
		int v;
		int e;
		v = int'(vcount_q);
		e = int'(ecount_q);
		if (v < 1) v = 1;
		if (v > MAX_VERTICES) v = MAX_VERTICES;
		if (e > MAX_EDGES) e = MAX_EDGES;
		nv = NVW'(v);
		ne = NEW'(e);
	end

	// ---------------- sequencer ----------------
	assign items.ready = (state_q == bf_pkg::ST_IDLE);
	assign run_acc     = items.valid && items.ready && (items.kind == bf_pkg::KIND_RUN);
	assign vtx_idx     = vtx_q[VAW-1:0];
	assign vtx_last    = (int'(vtx_q) + 1 == int'(nv));
	assign edge_last   = (int'(edge_q) + 1 == int'(ne));
	assign out_free    = !out_valid_q || results.ready;

	always_comb begin
		state_d  = state_q;
		vtx_d    = vtx_q;
		edge_d   = edge_q;
		pass_d   = pass_q;
		issue    = '0;
		init_we  = 1'b0;
		load_res = 1'b0;
		load_neg = 1'b0;
		unique case (state_q)
			bf_pkg::ST_IDLE: begin
				if (run_acc) begin
					issue.clear = 1'b1;
					vtx_d = '0;
					state_d = bf_pkg::ST_INIT;
				end
			end
			bf_pkg::ST_INIT: begin
				init_we = 1'b1;
				if (vtx_last) begin
					vtx_d  = '0;
					edge_d = '0;
					pass_d = NVW'(1);
					state_d = (ne == '0) ? bf_pkg::ST_DRAIN : bf_pkg::ST_RELAX;
				end else begin
					vtx_d = vtx_q + 1'b1;
				end
			end
			bf_pkg::ST_RELAX: begin
				// pass nv is the detection pass
				issue.valid = 1'b1;
				issue.check = (pass_q == nv);
				if (edge_last) begin
					edge_d = '0;
					if (issue.check) begin
						state_d = bf_pkg::ST_DRAIN;
					end else begin
						pass_d = pass_q + 1'b1;
					end
				end else begin
					edge_d = edge_q + 1'b1;
				end
			end
			bf_pkg::ST_DRAIN: begin
				if (!rlx_stat.busy) begin
					vtx_d = '0;
					state_d = rlx_stat.neg ? bf_pkg::ST_NEG : bf_pkg::ST_RD;
				end
			end
			bf_pkg::ST_RD: begin
				state_d = bf_pkg::ST_EMIT;
			end
			bf_pkg::ST_EMIT: begin
				if (out_free) begin
					load_res = 1'b1;
					if (vtx_last) begin
						state_d = bf_pkg::ST_IDLE;
					end else begin
						vtx_d = vtx_q + 1'b1;
						state_d = bf_pkg::ST_RD;
					end
				end
			end
			bf_pkg::ST_NEG: begin
				if (out_free) begin
					load_neg = 1'b1;
					state_d = bf_pkg::ST_IDLE;
				end
			end
			default: state_d = bf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bf_pkg::ST_IDLE;
			vtx_q   <= '0;
			edge_q  <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			vtx_q   <= vtx_d;
			edge_q  <= edge_d;
			pass_q  <= pass_d;
		end
	end

	always_ff @(posedge clk) begin
		if (run_acc) begin
			start_q <= items.start_vertex;
		end
	end

	// ---------------- edge store ----------------
	assign edge_we    = items.valid && items.ready && (items.kind == bf_pkg::KIND_LOAD)
	                    && (int'(items.edge_slot) < MAX_EDGES);
	assign edge_wdata = {items.from_vertex, items.to_vertex, items.edge_weight};

	bf_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (EAW'(items.edge_slot)),
		.wdata (edge_wdata),
		.raddr (edge_q),
		.rdata (edge_rdata)
	);

	// ---------------- distance store: two mirrored copies give two read ports ----------------
	always_comb begin
		if (init_we) begin
			dist_we    = 1'b1;
			dist_waddr = vtx_idx;
			dist_wdata = {(int'(start_q) < int'(nv)) && (int'(start_q) == int'(vtx_q)),
			              {DW{1'b0}}};
		end else begin
			dist_we    = rlx_we;
			dist_waddr = rlx_waddr;
			dist_wdata = rlx_wdata;
		end
		rd_addr_a = (state_q == bf_pkg::ST_RD || state_q == bf_pkg::ST_EMIT) ? vtx_idx
		            : rlx_raddr_s;
		rd_addr_b = rlx_raddr_d;
	end

	bf_ram #(.WIDTH(DEW), .DEPTH(MAX_VERTICES)) u_dist_ram_a (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	bf_ram #(.WIDTH(DEW), .DEPTH(MAX_VERTICES)) u_dist_ram_b (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (rd_addr_b),
		.rdata (rdata_b)
	);

	bf_relax #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_relax (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.edge_rdata (edge_rdata),
		.nv         (nv),
		.raddr_s    (rlx_raddr_s),
		.raddr_d    (rlx_raddr_d),
		.rdata_s    (rdata_a),
		.rdata_d    (rdata_b),
		.we         (rlx_we),
		.waddr      (rlx_waddr),
		.wdata      (rlx_wdata),
		.stat       (rlx_stat)
	);

	// ---------------- result register ----------------
	assign rd_dist = rdata_a[DW-1:0];
	assign rd_wide = longint'(rd_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res || load_neg) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			vertex_q    <= VB'(vtx_q);
			distance_q  <= rdata_a[DW] ? bf_pkg::sat_dist(rd_wide) : '0;
			reachable_q <= rdata_a[DW];
			negcyc_q    <= 1'b0;
			last_q      <= vtx_last;
		end else if (load_neg) begin
			vertex_q    <= '0;
			distance_q  <= '0;
			reachable_q <= 1'b0;
			negcyc_q    <= 1'b1;
			last_q      <= 1'b1;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.vertex         = vertex_q;
	assign results.distance       = distance_q;
	assign results.reachable      = reachable_q;
	assign results.negative_cycle = negcyc_q;
	assign results.last           = last_q;

	// ---------------- assertions ----------------
	`BF_ASSERT_NOW(a_idle_quiet, state_q == bf_pkg::ST_IDLE, !rlx_stat.busy, "relax busy while idle")
	`BF_ASSERT_NOW(a_wb_phase, rlx_we, state_q == bf_pkg::ST_RELAX || state_q == bf_pkg::ST_DRAIN, "distance write-back outside relaxation")
	`BF_ASSERT_NEXT(a_last_idle, (load_res && vtx_last) || load_neg, state_q == bf_pkg::ST_IDLE, "run did not end after last word")
	`BF_ASSERT_NOW(a_neg_last, out_valid_q && negcyc_q, last_q && !reachable_q, "cycle word malformed")
endmodule

// File: test/tb_top.sv
// Testbench for the shortest-path engine: edge loads and runs checked against a local predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int RANDOM_ITEMS = 430;
	localparam int VB = bf_pkg::VTX_BITS;
	localparam int SB = bf_pkg::SLOT_BITS;
	localparam int WB = bf_pkg::WEIGHT_BITS_DEF;

	typedef struct packed {
		logic [VB-1:0]                           vertex;
		logic signed [bf_pkg::DIST_OUT_BITS-1:0] distance;
		logic                                    reachable;
		logic                                    negative_cycle;
		logic                                    last;
	} path_word_t;

	typedef struct packed {
		logic                         kind;
		logic [bf_pkg::SLOT_BITS-1:0] edge_slot;
		logic [VB-1:0]                from_vertex;
		logic [VB-1:0]                to_vertex;
		logic signed [WB-1:0]         edge_weight;
		logic [VB-1:0]                start_vertex;
	} graph_cmd_t;

	typedef struct {
		int         vc;
		int         ec;
		graph_cmd_t cmd;
		bit         typed;
		path_word_t want;
	} path_case_t;

	// single-word outcomes that need no predictor
	localparam path_word_t LONE_START = '{6'd0, 22'sd0, 1'b1, 1'b0, 1'b1};
	localparam path_word_t OFF_GRAPH  = '{6'd0, 22'sd0, 1'b0, 1'b0, 1'b1};
	localparam path_word_t NEG_CYCLE  = '{6'd0, 22'sd0, 1'b0, 1'b1, 1'b1};

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [bf_pkg::CFG_ADDR_BITS-1:0] paddr;
	logic [bf_pkg::CFG_DATA_BITS-1:0] pwdata;
	logic [bf_pkg::CFG_DATA_BITS-1:0] prdata;
	logic                             pready;

	bf_in_if #(.WEIGHT_BITS(WB)) items_ch();
	bf_out_if results_ch();

	bellman_ford_shortest_paths DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items_ch),
		.results (results_ch)
	);

	path_word_t           pending_paths[$];
	path_case_t           directed_cases[$];
	logic [6:0]           vcount_reg;
	logic [8:0]           ecount_reg;
	logic [VB-1:0]        edge_src[256];
	logic [VB-1:0]        edge_dst[256];
	logic signed [WB-1:0] edge_wt[256];
	int                   mismatches = 0;
	int                   words_seen = 0;
	int                   cycle_count = 0;
	int                   random_sent = 0;
	bit                   burst = 0;

	function automatic int live_vertices();
		if (vcount_reg == 0)
			return 1;
		return (vcount_reg > 64) ? 64 : int'(vcount_reg);
	endfunction

	function automatic int live_edges();
		return (ecount_reg > 256) ? 256 : int'(ecount_reg);
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	// relaxation passes, then one detection pass; queues the words the run must produce
	task automatic predict_paths(input logic [VB-1:0] start);
		longint     dist_v[64];
		bit         reach[64];
		int         nv, ne, s, d;
		bit         cycle;
		longint     cand, dv;
		path_word_t w;
		nv = live_vertices();
		ne = live_edges();
		cycle = 0;
		for (int i = 0; i < 64; i++) begin
			dist_v[i] = 0;
			reach[i] = 0;
		end
		if (int'(start) < nv)
			reach[start] = 1;
		for (int p = 1; p <= nv && !cycle; p++)
			for (int j = 0; j < ne && !cycle; j++) begin
				s = int'(edge_src[j]);
				d = int'(edge_dst[j]);
				if (s < nv && d < nv && reach[s]) begin
					cand = dist_v[s] + longint'(edge_wt[j]);
					if (!reach[d] || cand < dist_v[d]) begin
						if (p == nv)
							cycle = 1;
						else begin
							dist_v[d] = cand;
							reach[d] = 1;
						end
					end
				end
			end
		if (cycle) begin
			pending_paths.push_back(NEG_CYCLE);
		end else begin
			for (int i = 0; i < nv; i++) begin
				dv = 0;
				if (reach[i]) begin
					dv = dist_v[i];
					if (dv > 64'sd2097151) dv = 64'sd2097151;
					if (dv < -64'sd2097152) dv = -64'sd2097152;
				end
				w.vertex = i[VB-1:0];
				w.distance = dv[bf_pkg::DIST_OUT_BITS-1:0];
				w.reachable = reach[i];
				w.negative_cycle = 1'b0;
				w.last = (i == nv - 1);
				pending_paths.push_back(w);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic graph_cmd_t load_cmd(int slot, int src, int dst, int wt);
		graph_cmd_t c;
		c.kind = bf_pkg::KIND_LOAD;
		c.edge_slot = SB'(slot);
		c.from_vertex = VB'(src);
		c.to_vertex = VB'(dst);
		c.edge_weight = WB'(wt);
		c.start_vertex = VB'($urandom_range(0, 63));
		return c;
	endfunction

	function automatic graph_cmd_t run_cmd(int start);
		graph_cmd_t c;
		c.kind = bf_pkg::KIND_RUN;
		c.edge_slot = SB'($urandom_range(0, 255));
		c.from_vertex = VB'($urandom_range(0, 63));
		c.to_vertex = VB'($urandom_range(0, 63));
		c.edge_weight = WB'($urandom_range(0, 65535));
		c.start_vertex = VB'(start);
		return c;
	endfunction

	// mostly forward edges or non-negative weights so that many runs end without a cycle
	function automatic graph_cmd_t shaped_load(int slot, int nv);
		int r, a, b, wt;
		r = $urandom_range(0, 9);
		if (r < 6 && nv >= 2) begin
			a = $urandom_range(0, nv - 2);
			b = $urandom_range(a + 1, nv - 1);
			wt = $urandom_range(0, 65535);
		end else if (r < 9) begin
			a = $urandom_range(0, nv - 1);
			b = $urandom_range(0, nv - 1);
			wt = $urandom_range(0, 32767);
		end else begin
			a = $urandom_range(0, 63);
			b = $urandom_range(0, 63);
			wt = $urandom_range(0, 65535);
		end
		return load_cmd(slot, a, b, wt);
	endfunction

	function automatic void add_case(int vc, int ec, graph_cmd_t cmd, bit typed, path_word_t want);
		path_case_t pc;
		pc.vc = vc;
		pc.ec = ec;
		pc.cmd = cmd;
		pc.typed = typed;
		pc.want = want;
		directed_cases.push_back(pc);
	endfunction

	// present one word and wait for it to be taken; the predictor follows on acceptance
	task automatic offer(input graph_cmd_t c, input bit typed, input path_word_t want);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.kind <= c.kind;
		items_ch.edge_slot <= c.edge_slot;
		items_ch.from_vertex <= c.from_vertex;
		items_ch.to_vertex <= c.to_vertex;
		items_ch.edge_weight <= c.edge_weight;
		items_ch.start_vertex <= c.start_vertex;
		do @(posedge clk); while (!items_ch.ready);
		if (c.kind == bf_pkg::KIND_LOAD) begin
			edge_src[c.edge_slot] = c.from_vertex;
			edge_dst[c.edge_slot] = c.to_vertex;
			edge_wt[c.edge_slot] = c.edge_weight;
		end else if (typed) begin
			pending_paths.push_back(want);
		end else begin
			predict_paths(c.start_vertex);
		end
	endtask

	// stop sending, let every word out, and give a trailing load time to finish
	task automatic settle();
		items_ch.valid <= 1'b0;
		while (pending_paths.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		logic [31:0] data, stored;
		data = $urandom;
		if ($urandom_range(0, 1))
			data = '0;
		if (idx == bf_pkg::REG_VERTEX_COUNT) begin
			data[6:0] = 7'(value);
			stored = {25'b0, data[6:0]};
		end else begin
			data[8:0] = 9'(value);
			stored = {23'b0, data[8:0]};
		end
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bf_pkg::REG_VERTEX_COUNT)
			vcount_reg = data[6:0];
		else
			ecount_reg = data[8:0];
		// read back straight away
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored)
			flag_error($sformatf("register %0d read back: expected %0h, got %0h",
				idx, stored, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side: checks each word, idles at random, and at most twice holds off for long
	initial begin
		int         hold;
		int         long_holds;
		int         r;
		bit         rdy;
		path_word_t got, want;
		hold = 0;
		long_holds = 0;
		rdy = 1'b0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready) begin
				got.vertex = results_ch.vertex;
				got.distance = results_ch.distance;
				got.reachable = results_ch.reachable;
				got.negative_cycle = results_ch.negative_cycle;
				got.last = results_ch.last;
				words_seen++;
				if (pending_paths.size() == 0) begin
					flag_error($sformatf("unexpected word: v %0d d %0d r %0b n %0b l %0b",
						got.vertex, got.distance, got.reachable, got.negative_cycle, got.last));
				end else begin
					want = pending_paths.pop_front();
					if (got.vertex !== want.vertex || got.distance !== want.distance ||
					    got.reachable !== want.reachable ||
					    got.negative_cycle !== want.negative_cycle || got.last !== want.last)
						flag_error($sformatf({"word mismatch: expected v %0d d %0d r %0b n %0b l %0b,",
							" got v %0d d %0d r %0b n %0b l %0b"},
							want.vertex, want.distance, want.reachable, want.negative_cycle,
							want.last, got.vertex, got.distance, got.reachable,
							got.negative_cycle, got.last));
				end
			end
			if (long_holds < 2 && words_seen > 60 + 240 * long_holds &&
			    items_ch.valid && !items_ch.ready && results_ch.valid) begin
				// input is blocked behind pending words: starve the output side
				rdy = 1'b0;
				hold = 2000;
				long_holds++;
			end else if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					rdy = 1'b1;
					hold = $urandom_range(1, 12);
				end else if (r < 80) begin
					rdy = 1'b0;
					hold = $urandom_range(1, 3);
				end else if (r < 92) begin
					rdy = 1'b1;
					hold = $urandom_range(50, 150);
				end else begin
					rdy = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end else begin
				hold--;
			end
			results_ch.ready <= rdy;
		end
	end

	initial begin
		int r, v, e, nv, ne, nl, nr, left, slot, start;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		items_ch.valid <= 1'b0;
		items_ch.kind <= bf_pkg::KIND_LOAD;
		items_ch.edge_slot <= '0;
		items_ch.from_vertex <= '0;
		items_ch.to_vertex <= '0;
		items_ch.edge_weight <= '0;
		items_ch.start_vertex <= '0;
		vcount_reg = 7'd1;
		ecount_reg = 9'd0;

		// after reset: one vertex, no edges
		add_case(1, 0, run_cmd(0), 1, LONE_START);
		add_case(1, 0, run_cmd(63), 1, OFF_GRAPH);
		// 0->1->2->0 is a cycle of weight -1; 2->63 leaves small graphs
		add_case(1, 0, load_cmd(0, 0, 1, 32767), 0, '0);
		add_case(1, 0, load_cmd(1, 1, 2, -32768), 0, '0);
		add_case(1, 0, load_cmd(2, 2, 63, -1), 0, '0);
		add_case(1, 0, load_cmd(3, 3, 3, 5), 0, '0);
		add_case(1, 0, load_cmd(4, 2, 0, 0), 0, '0);
		add_case(1, 0, load_cmd(255, 63, 0, 0), 0, '0);
		add_case(4, 4, run_cmd(0), 0, '0);
		add_case(4, 5, run_cmd(0), 1, NEG_CYCLE);
		// cycle exists but cannot be reached from vertex 3
		add_case(4, 5, run_cmd(3), 0, '0);
		add_case(4, 5, run_cmd(4), 0, '0);
		// vertex count of zero behaves as one
		add_case(0, 3, run_cmd(0), 1, LONE_START);
		// vertex count beyond the maximum is clamped
		add_case(127, 4, run_cmd(63), 0, '0);
		add_case(127, 4, run_cmd(0), 0, '0);
		add_case(2, 0, run_cmd(1), 0, '0);
		add_case(2, 0, load_cmd(5, 63, 63, -32768), 0, '0);
		add_case(64, 6, run_cmd(63), 1, NEG_CYCLE);
		add_case(64, 6, run_cmd(0), 1, NEG_CYCLE);
		add_case(64, 6, run_cmd(5), 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i]) begin
			if (directed_cases[i].vc != vcount_reg || directed_cases[i].ec != ecount_reg) begin
				settle();
				if (directed_cases[i].vc != vcount_reg)
					write_reg(bf_pkg::REG_VERTEX_COUNT, directed_cases[i].vc);
				if (directed_cases[i].ec != ecount_reg)
					write_reg(bf_pkg::REG_EDGE_COUNT, directed_cases[i].ec);
			end
			offer(directed_cases[i].cmd, directed_cases[i].typed, directed_cases[i].want);
		end

		// fill the whole edge store so that any edge count is legal from here on
		burst = 1;
		for (int s = 0; s < 256; s++) begin
			offer(shaped_load(s, 64), 0, '0);
			random_sent++;
		end
		burst = 0;

		// full-size runs, clamped and exact
		for (int x = 0; x < 2; x++) begin
			settle();
			write_reg(bf_pkg::REG_VERTEX_COUNT, (x == 0) ? 127 : 64);
			write_reg(bf_pkg::REG_EDGE_COUNT, (x == 0) ? 511 : 256);
			for (int k = 0; k < 2; k++) begin
				offer(run_cmd($urandom_range(0, 63)), 0, '0);
				random_sent++;
			end
		end

		while (random_sent < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 6) begin
				v = $urandom_range(2, 8);
				e = $urandom_range(0, 24);
			end else if (r < 8) begin
				v = $urandom_range(9, 30);
				e = $urandom_range(0, 32);
			end else if (r == 8) begin
				case ($urandom_range(0, 3))
					0: v = 0;
					1: v = 1;
					2: v = 63;
					default: v = 64;
				endcase
				e = $urandom_range(0, 16);
			end else begin
				v = $urandom_range(31, 63);
				e = $urandom_range(0, 12);
			end
			write_reg(bf_pkg::REG_VERTEX_COUNT, v);
			write_reg(bf_pkg::REG_EDGE_COUNT, e);
			burst = ($urandom_range(0, 3) == 0);
			nv = live_vertices();
			ne = live_edges();
			nl = $urandom_range(0, ne) + $urandom_range(0, 2);
			nr = $urandom_range(2, 5);
			left = nl + nr;
			while (left > 0) begin
				if ($urandom_range(1, left) <= nr) begin
					start = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nv - 1)
					                                      : $urandom_range(0, 63);
					offer(run_cmd(start), 0, '0);
					nr--;
				end else begin
					slot = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (ne > 0) ? ne - 1 : 0)
					                                     : $urandom_range(0, 255);
					offer(shaped_load(slot, nv), 0, '0);
				end
				left--;
				random_sent++;
			end
		end

		items_ch.valid <= 1'b0;
		while (pending_paths.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bf_pkg.sv
rtl/core/bf_in_if.sv
rtl/core/bf_out_if.sv
rtl/core/bf_ram.sv
rtl/core/bf_relax.sv
rtl/core/bellman_ford_shortest_paths.sv
test/tb_top.sv
